FILE: rtl/core/imdu_pkg.sv
`timescale 1ns / 1ps

package imdu_pkg;

   // Operand word width. The operand fields of an item are fixed at this width.
   localparam int DataWidth  = 32;
   localparam int CountWidth = $clog2(DataWidth);
   localparam logic [CountWidth-1:0] LastStep = CountWidth'(DataWidth - 1);

   // Action codes. Bit 0 selects signed operands, bit 1 selects divide.
   localparam logic [1:0] ACT_MUL_U = 2'd0;
   localparam logic [1:0] ACT_MUL_S = 2'd1;
   localparam logic [1:0] ACT_DIV_U = 2'd2;
   localparam logic [1:0] ACT_DIV_S = 2'd3;

   typedef struct packed {
      logic [1:0]           action;
      logic [DataWidth-1:0] operand_a;
      logic [DataWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_hi;
      logic [DataWidth-1:0] result_lo;
      logic                 divide_by_zero;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic write_out;
   } cmd_type;

endpackage

FILE: rtl/core/int_mul_div_unit_32.sv
`timescale 1ns / 1ps

// Iterative 32-bit integer multiply / divide unit.
//
// An item on the req_ channel carries an action code and two 32-bit operands:
// unsigned or signed multiply, unsigned or signed divide. Each item yields one
// item on the rsp_ channel. A multiply returns the 64-bit product as high and
// low words. A divide returns the quotient in result_hi and the remainder in
// result_lo; signed division truncates toward zero and the remainder carries
// the dividend's sign. A zero divisor sets divide_by_zero and returns an
// all-ones quotient with the dividend as remainder.
//
// An accepted item runs through a shift-and-add / restoring subtract
// iteration, one operand bit per cycle, and then a sign fix-up. The unit is
// idle again once the fix-up has written the output register, so it takes a
// new item only after it is through with the last one. req_stall is high
// while an item is in the iteration or the fix-up.
// The result waits in an output register while rsp_stall is high, and the
// unit already accepts and works on the next item meanwhile; it holds in its
// fix-up state only when that register is still occupied.
// The synchronous reset empties the unit and drops rsp_valid.

module int_mul_div_unit_32
   import imdu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;

   // Sequencer: accepts items, counts the 32 iteration steps and manages
   // the output register's valid flag.
   imdu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Operand registers, the add/subtract step and the fix-up logic.
   imdu_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/core/imdu_ctrl.sv
`timescale 1ns / 1ps

module imdu_ctrl
   import imdu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (count_ff == LastStep) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      count_in     = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
         end
         ST_FIX: begin
            cmd.write_out = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RUN) |-> (count_ff == '0))
      else $error("step counter not clear outside the run state");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RUN))
      else $error("accepted item did not start the iteration");

   a_write_in_fix: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |-> (state_ff == ST_FIX))
      else $error("output written outside the fix-up state");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write_out |=> rsp_valid_ff)
      else $error("written result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.write_out)
      else $error("waiting result overwritten");

endmodule

FILE: rtl/core/imdu_dp.sv
`timescale 1ns / 1ps

module imdu_dp
   import imdu_pkg::*;
(
   input  logic    clock,
   input  req_type req_data,
   input  cmd_type cmd,
   output rsp_type rsp_data
);

   logic [DataWidth-1:0] hi_ff, hi_in;
   logic [DataWidth-1:0] lo_ff, lo_in;
   logic [DataWidth-1:0] mcand_ff;
   logic [DataWidth-1:0] a_raw_ff;
   logic                 is_div_ff, neg_hi_ff, neg_lo_ff, div_zero_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 signed_op, divide_op, neg_a, neg_b;
   logic [DataWidth-1:0] a_mag, b_mag;
   logic [DataWidth:0]   mul_sum, div_shift, div_diff;
   logic                 div_ok;
   logic [2*DataWidth-1:0] product;

   // Operand magnitudes for the signed actions.
   always_comb begin
      signed_op = (req_data.action == ACT_MUL_S) || (req_data.action == ACT_DIV_S);
      divide_op = (req_data.action == ACT_DIV_U) || (req_data.action == ACT_DIV_S);
      neg_a     = signed_op && req_data.operand_a[DataWidth-1];
      neg_b     = signed_op && req_data.operand_b[DataWidth-1];
      a_mag     = neg_a ? (~req_data.operand_a + 1'b1) : req_data.operand_a;
      b_mag     = neg_b ? (~req_data.operand_b + 1'b1) : req_data.operand_b;
   end

   // One multiply step: add the multiplicand when the low bit is set, shift right.
   // One divide step: shift the remainder left, subtract the divisor if it fits.
   always_comb begin
      mul_sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      div_shift = {hi_ff, lo_ff[DataWidth-1]};
      div_diff  = div_shift - {1'b0, mcand_ff};
      div_ok    = !div_diff[DataWidth];
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      if (cmd.load) begin
         hi_in = '0;
         lo_in = divide_op ? a_mag : b_mag;
      end else if (cmd.step) begin
         if (is_div_ff) begin
            hi_in = div_ok ? div_diff[DataWidth-1:0] : div_shift[DataWidth-1:0];
            lo_in = {lo_ff[DataWidth-2:0], div_ok};
         end else begin
            hi_in = mul_sum[DataWidth:1];
            lo_in = {mul_sum[0], lo_ff[DataWidth-1:1]};
         end
      end
   end

   // Sign fix-up and the zero-divisor answer.
   always_comb begin
      product = {hi_ff, lo_ff};
      if (neg_hi_ff) begin
         product = ~product + 1'b1;
      end
      rsp_in.divide_by_zero = 1'b0;
      if (!is_div_ff) begin
         rsp_in.result_hi = product[2*DataWidth-1:DataWidth];
         rsp_in.result_lo = product[DataWidth-1:0];
      end else if (div_zero_ff) begin
         rsp_in.result_hi      = '1;
         rsp_in.result_lo      = a_raw_ff;
         rsp_in.divide_by_zero = 1'b1;
      end else begin
         rsp_in.result_hi = neg_hi_ff ? (~lo_ff + 1'b1) : lo_ff;
         rsp_in.result_lo = neg_lo_ff ? (~hi_ff + 1'b1) : hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (cmd.load) begin
         mcand_ff    <= divide_op ? b_mag : a_mag;
         a_raw_ff    <= req_data.operand_a;
         is_div_ff   <= divide_op;
         neg_hi_ff   <= neg_a ^ neg_b;
         neg_lo_ff   <= neg_a;
         div_zero_ff <= divide_op && (req_data.operand_b == '0);
      end
      if (cmd.write_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
